/* rtl/wht_pkg.sv */
// Shared command, status and operation types for the Walsh-Hadamard transform unit.
package wht_pkg;

  // Operation carried by a controller command
  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_BFLY  = 2'd1,
    OP_SCALE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Command from controller to datapath, at most one per cycle (valid low while draining or showing a pair)
  typedef struct packed {
    logic valid;
    op_t  op;
    logic src;
  } cmd_t;

  // Status from datapath back to controller
  typedef struct packed {
    logic busy;
  } status_t;

endpackage

/* rtl/wht_ctrl.sv */
// Sequencer for fill, butterfly passes, scaling pass and pair output.
module wht_ctrl import wht_pkg::*; #(
  parameter int POINTS = 128,
  localparam int AW = $clog2(POINTS),
  localparam int SW = $clog2(AW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          last_pair,
  output cmd_t          cmd,
  output logic [AW-1:0] cmd_index,
  output logic [SW-1:0] cmd_stride,
  input  status_t       status
);

  typedef enum logic [2:0] {
    S_FILL,
    S_BFLY,
    S_BDRAIN,
    S_SCALE,
    S_SDRAIN,
    S_OREAD,
    S_OSHOW
  } state_t;

  state_t        state;
  logic [AW-1:0] idx;
  logic [SW-1:0] pass;
  logic          src;

  assign in_stall   = (state != S_FILL);
  assign cmd_index  = idx;
  assign cmd_stride = (state == S_BFLY) ? pass : '0;

  // Command decode from current state
  always_comb begin
    cmd.src = src;
    case (state)
      S_FILL: begin
        cmd.valid = in_valid;
        cmd.op    = OP_FILL;
      end
      S_BFLY: begin
        cmd.valid = 1'b1;
        cmd.op    = OP_BFLY;
      end
      S_SCALE: begin
        cmd.valid = 1'b1;
        cmd.op    = OP_SCALE;
      end
      S_OREAD: begin
        cmd.valid = 1'b1;
        cmd.op    = OP_READ;
      end
      default: begin
        cmd.valid = 1'b0;
        cmd.op    = OP_READ;
      end
    endcase
  end

  // State, counters and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      idx       <= '0;
      pass      <= '0;
      src       <= 1'b0;
      out_valid <= 1'b0;
      last_pair <= 1'b0;
    end else begin
      case (state)
        S_FILL: begin
          if (in_valid) begin
            idx <= idx + AW'(1);
            if (idx == AW'(POINTS - 1)) begin
              state <= S_BFLY;
              pass  <= '0;
              src   <= 1'b0;
            end
          end
        end
        S_BFLY: begin
          idx <= idx + AW'(1);
          if (idx == AW'(POINTS - 1)) state <= S_BDRAIN;
        end
        S_BDRAIN: begin
          if (!status.busy) begin
            src <= ~src;
            if (pass == SW'(AW - 1)) begin
              state <= S_SCALE;
            end else begin
              pass  <= pass + SW'(1);
              state <= S_BFLY;
            end
          end
        end
        S_SCALE: begin
          idx <= idx + AW'(1);
          if (idx == AW'(POINTS - 1)) state <= S_SDRAIN;
        end
        S_SDRAIN: begin
          if (!status.busy) begin
            src   <= ~src;
            state <= S_OREAD;
          end
        end
        S_OREAD: begin
          out_valid <= 1'b1;
          last_pair <= (idx == AW'(POINTS - 2));
          state     <= S_OSHOW;
        end
        S_OSHOW: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            idx       <= idx + AW'(2);
            state     <= last_pair ? S_FILL : S_OREAD;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

endmodule

/* rtl/wht_datapath.sv */
// Work banks, fp32 butterfly adder, fp32 scaler, bf16 rounding and sticky flags.
module wht_datapath import wht_pkg::*; #(
  parameter int POINTS = 128,
  localparam int AW = $clog2(POINTS),
  localparam int SW = $clog2(AW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          output_bf16,
  input  cmd_t          cmd,
  input  logic [AW-1:0] cmd_index,
  input  logic [SW-1:0] cmd_stride,
  input  logic [15:0]   sample,
  output status_t       status,
  output logic [31:0]   result_even,
  output logic [31:0]   result_odd,
  output logic          flag_nonfinite,
  output logic          flag_bf16_overflow
);

  localparam logic [23:0] INV_MANT    = 24'hB504F3; // 1/sqrt(128) significand
  localparam logic [9:0]  INV_EXP_ADJ = 10'd4;      // 127 - 123
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

  function automatic logic [4:0] clz27(input logic [26:0] v);
    logic [4:0] c;
    logic       found;
    c     = 5'd27;
    found = 1'b0;
    for (int k = 26; k >= 0; k--) begin
      if (!found && v[k]) begin
        c     = 5'(26 - k);
        found = 1'b1;
      end
    end
    return c;
  endfunction

  function automatic logic [5:0] clz48(input logic [47:0] v);
    logic [5:0] c;
    logic       found;
    c     = 6'd48;
    found = 1'b0;
    for (int k = 47; k >= 0; k--) begin
      if (!found && v[k]) begin
        c     = 6'(47 - k);
        found = 1'b1;
      end
    end
    return c;
  endfunction

  logic          mode;
  logic [31:0]   bank0 [POINTS];
  logic [31:0]   bank1 [POINTS];
  logic [31:0]   b0_rd_lo, b0_rd_hi, b1_rd_lo, b1_rd_hi;
  logic [AW-1:0] step, lo, hi, ra0;
  logic          rd_en, fill_we;
  logic          r_valid, r_src, r_sub, r_scale;
  logic [AW-1:0] r_addr;
  logic [31:0]   op_a, op_b;
  logic [3:0]    t_valid;
  logic          t_scale [4];
  logic          t_dst   [4];
  logic [AW-1:0] t_addr  [4];
  logic          b0_we, b1_we;
  logic [AW-1:0] b0_wa;
  logic [31:0]   b0_wd, wr_data;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (cfg_we) mode <= output_bf16;
  end

  // Butterfly addressing
  always_comb begin
    step    = AW'(1) << cmd_stride;
    lo      = cmd_index & ~step;
    hi      = lo | step;
    ra0     = (cmd.op == OP_SCALE) ? cmd_index : lo;
    fill_we = cmd.valid && (cmd.op == OP_FILL);
    rd_en   = cmd.valid && (cmd.op != OP_FILL);
  end

  // Bank reads, registered; held between read commands
  always_ff @(posedge clk) begin
    if (rd_en) begin
      b0_rd_lo <= bank0[ra0];
      b0_rd_hi <= bank0[hi];
      b1_rd_lo <= bank1[ra0];
      b1_rd_hi <= bank1[hi];
      r_src    <= cmd.src;
      r_sub    <= |(cmd_index & step);
      r_scale  <= (cmd.op == OP_SCALE);
      r_addr   <= cmd_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) r_valid <= 1'b0;
    else r_valid <= cmd.valid && (cmd.op == OP_BFLY || cmd.op == OP_SCALE);
  end

  assign op_a        = r_src ? b1_rd_lo : b0_rd_lo;
  assign op_b        = r_src ? b1_rd_hi : b0_rd_hi;
  assign result_even = op_a;
  assign result_odd  = op_b;

  // ---------------- adder stage 1: specials, order by magnitude
  logic [31:0] bx, ax, ay, a1_spec_val;
  logic        a_nan, a_inf, b_nan, b_inf, a1_spec;
  logic [7:0]  a1_ex, a1_ey;
  logic        s1_spec, s1_sign, s1_sub;
  logic [31:0] s1_spec_val;
  logic [7:0]  s1_ex, s1_d;
  logic [23:0] s1_mx, s1_my;

  always_comb begin
    bx    = {op_b[31] ^ r_sub, op_b[30:0]};
    a_nan = (&op_a[30:23]) && (|op_a[22:0]);
    a_inf = (&op_a[30:23]) && !(|op_a[22:0]);
    b_nan = (&op_b[30:23]) && (|op_b[22:0]);
    b_inf = (&op_b[30:23]) && !(|op_b[22:0]);
    a1_spec = a_nan | a_inf | b_nan | b_inf;
    if (a_nan) a1_spec_val = op_a | QUIET_BIT;
    else if (b_nan) a1_spec_val = op_b | QUIET_BIT;
    else if (a_inf && b_inf && (op_a[31] != bx[31])) a1_spec_val = DEFAULT_NAN;
    else if (a_inf) a1_spec_val = op_a;
    else a1_spec_val = bx;
    if (bx[30:0] > op_a[30:0]) begin
      ax = bx;
      ay = op_a;
    end else begin
      ax = op_a;
      ay = bx;
    end
    a1_ex = (ax[30:23] == 8'd0) ? 8'd1 : ax[30:23];
    a1_ey = (ay[30:23] == 8'd0) ? 8'd1 : ay[30:23];
  end

  always_ff @(posedge clk) begin
    s1_spec     <= a1_spec;
    s1_spec_val <= a1_spec_val;
    s1_sign     <= ax[31];
    s1_sub      <= ax[31] ^ ay[31];
    s1_ex       <= a1_ex;
    s1_d        <= a1_ex - a1_ey;
    s1_mx       <= {ax[30:23] != 8'd0, ax[22:0]};
    s1_my       <= {ay[30:23] != 8'd0, ay[22:0]};
  end

  // ---------------- adder stage 2: align and add
  logic [4:0]  dd;
  logic [53:0] al_t;
  logic [26:0] al;
  logic [27:0] sum;
  logic        s2_spec, s2_sign, s2_sub;
  logic [31:0] s2_spec_val;
  logic [7:0]  s2_ex;
  logic [27:0] s2_s;

  always_comb begin
    dd   = (s1_d > 8'd27) ? 5'd27 : s1_d[4:0];
    al_t = {s1_my, 3'b000, 27'd0} >> dd;
    al   = {al_t[53:28], al_t[27] | (|al_t[26:0])};
    if (s1_sub) sum = {1'b0, s1_mx, 3'b000} - {1'b0, al};
    else sum = {1'b0, s1_mx, 3'b000} + {1'b0, al};
  end

  always_ff @(posedge clk) begin
    s2_spec     <= s1_spec;
    s2_spec_val <= s1_spec_val;
    s2_sign     <= s1_sign;
    s2_sub      <= s1_sub;
    s2_ex       <= s1_ex;
    s2_s        <= sum;
  end

  // ---------------- adder stage 3: normalise
  logic [4:0]  lz27;
  logic [26:0] nrm;
  logic [8:0]  nexp;
  logic        s3_spec, s3_sign;
  logic [31:0] s3_spec_val;
  logic [26:0] s3_n;
  logic [8:0]  s3_e;

  always_comb begin
    lz27 = clz27(s2_s[26:0]);
    if (s2_s[27]) begin
      nrm  = {s2_s[27:2], s2_s[1] | s2_s[0]};
      nexp = {1'b0, s2_ex} + 9'd1;
    end else if ((s2_s != 28'd0) && ({3'b000, lz27} < s2_ex)) begin
      nrm  = s2_s[26:0] << lz27;
      nexp = {1'b0, s2_ex} - {4'b0000, lz27};
    end else begin
      // subnormal or exact zero
      nrm  = s2_s[26:0] << (s2_ex - 8'd1);
      nexp = 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    s3_spec     <= s2_spec;
    s3_spec_val <= s2_spec_val;
    // exact zero: +0 from a cancellation, else sign of the operands
    s3_sign     <= (s2_s == 28'd0) ? (s2_sign & ~s2_sub) : s2_sign;
    s3_n        <= nrm;
    s3_e        <= nexp;
  end

  // ---------------- adder stage 4: round to nearest even
  logic        a_up;
  logic [30:0] a_mag;
  logic [31:0] a4_res;

  always_comb begin
    a_up  = s3_n[2] & (s3_n[1] | s3_n[0] | s3_n[3]);
    a_mag = {s3_e[7:0], s3_n[25:3]} + 31'(a_up);
  end

  always_ff @(posedge clk) begin
    if (s3_spec) a4_res <= s3_spec_val;
    else if (s3_e >= 9'd255) a4_res <= {s3_sign, 8'hFF, 23'd0};
    else a4_res <= {s3_sign, a_mag};
  end

  // ---------------- scaler stage 1: specials and significand product
  logic        v_nan, v_inf, v_zero;
  logic [7:0]  v_ev;
  logic [23:0] v_mv;
  logic        m1_spec, m1_sign;
  logic [31:0] m1_spec_val;
  logic [47:0] m1_p;
  logic [9:0]  m1_e0;

  always_comb begin
    v_nan  = (&op_a[30:23]) && (|op_a[22:0]);
    v_inf  = (&op_a[30:23]) && !(|op_a[22:0]);
    v_zero = (op_a[30:0] == 31'd0);
    v_ev   = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
    v_mv   = {op_a[30:23] != 8'd0, op_a[22:0]};
  end

  always_ff @(posedge clk) begin
    m1_spec     <= v_nan | v_inf | v_zero;
    m1_spec_val <= v_nan ? (op_a | QUIET_BIT) : (v_inf ? op_a : {op_a[31], 31'd0});
    m1_sign     <= op_a[31];
    m1_p        <= {24'd0, v_mv} * {24'd0, INV_MANT};
    m1_e0       <= {2'b00, v_ev} - INV_EXP_ADJ;
  end

  // ---------------- scaler stage 2: normalise, subnormal alignment
  logic [5:0]  lz48;
  logic [9:0]  m_e, neg_e0;
  logic [50:0] m_rt;
  logic [47:0] m_q;
  logic [7:0]  m_field;
  logic        m_st;
  logic        m2_spec, m2_sign, m2_st;
  logic [31:0] m2_spec_val;
  logic [47:0] m2_q;
  logic [7:0]  m2_field;

  always_comb begin
    lz48   = clz48(m1_p);
    m_e    = m1_e0 + 10'd1 - {4'b0000, lz48};
    neg_e0 = 10'd0 - m1_e0;
    m_rt   = {m1_p, 3'b000} >> neg_e0[1:0];
    m_st   = 1'b0;
    if (!m_e[9] && (m_e != 10'd0)) begin
      m_q     = m1_p << lz48;
      m_field = m_e[7:0];
    end else if (!m1_e0[9]) begin
      m_q     = m1_p << m1_e0[5:0];
      m_field = 8'd0;
    end else begin
      m_q     = m_rt[50:3];
      m_st    = |m_rt[2:0];
      m_field = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    m2_spec     <= m1_spec;
    m2_spec_val <= m1_spec_val;
    m2_sign     <= m1_sign;
    m2_q        <= m_q;
    m2_field    <= m_field;
    m2_st       <= m_st;
  end

  // ---------------- scaler stage 3: round to nearest even
  logic        m_up;
  logic [30:0] m_mag;
  logic [31:0] m3_r;

  always_comb begin
    m_up  = m2_q[23] & (m2_q[24] | (|m2_q[22:0]) | m2_st);
    m_mag = {m2_field, m2_q[46:24]} + 31'(m_up);
  end

  always_ff @(posedge clk) begin
    m3_r <= m2_spec ? m2_spec_val : {m2_sign, m_mag};
  end

  // ---------------- scaler stage 4: bf16 rounding and flag terms
  logic        r_is_nan;
  logic [31:0] r_rnd;
  logic [15:0] h16;
  logic [31:0] m4_word;
  logic        m4_nf, m4_ov;

  always_comb begin
    r_is_nan = (m3_r[30:0] > 31'h7F80_0000);
    r_rnd    = m3_r + 32'h0000_7FFF + {31'd0, m3_r[16]};
    h16      = r_is_nan ? (m3_r[31:16] | 16'h0040) : r_rnd[31:16];
  end

  always_ff @(posedge clk) begin
    m4_word <= mode ? {16'd0, h16} : m3_r;
    m4_nf   <= &m3_r[30:23];
    m4_ov   <= mode & (&h16[14:7]);
  end

  // ---------------- transaction tags alongside the arithmetic
  always_ff @(posedge clk) begin
    if (rst) t_valid <= '0;
    else t_valid <= {t_valid[2:0], r_valid};
  end

  always_ff @(posedge clk) begin
    t_scale[0] <= r_scale;
    t_dst[0]   <= ~r_src;
    t_addr[0]  <= r_addr;
    for (int k = 1; k < 4; k++) begin
      t_scale[k] <= t_scale[k-1];
      t_dst[k]   <= t_dst[k-1];
      t_addr[k]  <= t_addr[k-1];
    end
  end

  assign status.busy = r_valid | (|t_valid);

  // Bank writes: sample fill or pipeline result
  always_comb begin
    wr_data = t_scale[3] ? m4_word : a4_res;
    b0_we   = fill_we | (t_valid[3] & ~t_dst[3]);
    b1_we   = t_valid[3] & t_dst[3];
    b0_wa   = fill_we ? cmd_index : t_addr[3];
    b0_wd   = fill_we ? {sample, 16'd0} : wr_data;
  end

  always_ff @(posedge clk) begin
    if (b0_we) bank0[b0_wa] <= b0_wd;
  end

  always_ff @(posedge clk) begin
    if (b1_we) bank1[t_addr[3]] <= wr_data;
  end

  // Sticky flags
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_nonfinite     <= 1'b0;
      flag_bf16_overflow <= 1'b0;
    end else begin
      if (fill_we && (&sample[14:7])) flag_nonfinite <= 1'b1;
      if (t_valid[3] && t_scale[3]) begin
        if (m4_nf) flag_nonfinite <= 1'b1;
        if (m4_ov) flag_bf16_overflow <= 1'b1;
      end
    end
  end

endmodule

/* rtl/walsh_hadamard_128_bf16_unit.sv */
// Top level of the 128-point bf16 Walsh-Hadamard transform unit.
// Usage:
//  - Input channel (in_valid, in_stall, sample): one bf16 sample per transaction,
//    index 0 of a block first. Samples are taken one per cycle while the unit fills.
//  - Once POINTS samples are in, in_stall stays high while the unit runs log2(POINTS)
//    butterfly passes and one scaling pass, each issuing one command per point and
//    then draining the fp32 pipeline through the two work banks.
//  - Output channel (out_valid, out_stall): POINTS/2 transactions, each one pair
//    result_even/result_odd, last_pair high on the final pair; a single bank read
//    serves each pair, and the next pair is read only after the last one is taken.
//  - A stalled pair holds all output fields; the unit waits and takes no samples
//    until every pair of the block has been delivered.
//  - Config channel (cfg_valid, cfg_ready, output_bf16) selects fp32 or bf16 results;
//    cfg_ready is always high, writes are expected only between blocks.
//  - Synchronous reset clears the fill position, the mode and both sticky flags.
module walsh_hadamard_128_bf16_unit import wht_pkg::*; #(
  parameter int POINTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_even,
  output logic [31:0] result_odd,
  output logic        last_pair,
  output logic        flag_nonfinite,
  output logic        flag_bf16_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        output_bf16
);

  localparam int AW = $clog2(POINTS);
  localparam int SW = $clog2(AW + 1);

  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] cmd_index;
  logic [SW-1:0] cmd_stride;

  assign cfg_ready = 1'b1;

  wht_ctrl #(.POINTS(POINTS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .last_pair  (last_pair),
    .cmd        (cmd),
    .cmd_index  (cmd_index),
    .cmd_stride (cmd_stride),
    .status     (status)
  );

  wht_datapath #(.POINTS(POINTS)) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_valid & cfg_ready),
    .output_bf16        (output_bf16),
    .cmd                (cmd),
    .cmd_index          (cmd_index),
    .cmd_stride         (cmd_stride),
    .sample             (sample),
    .status             (status),
    .result_even        (result_even),
    .result_odd         (result_odd),
    .flag_nonfinite     (flag_nonfinite),
    .flag_bf16_overflow (flag_bf16_overflow)
  );

endmodule
